>>> rtl/iphc_pkg.sv
// ----------------------------------------------------------------------------
// IPHC header compression package
// Shared types, segment codes and header constants for the IPHC compressor.
// ----------------------------------------------------------------------------
package iphc_pkg;

  // Depth of the queue between the classifier and the byte serializer.
  localparam int QUEUE_DEPTH_DEFAULT = 2;

  // Header constants.
  localparam logic [2:0]  IPHC_DISPATCH     = 3'b011;
  localparam logic [7:0]  PROTO_UDP         = 8'd17;
  localparam logic [7:0]  HOPS_LEFT_1       = 8'd1;
  localparam logic [7:0]  HOPS_LEFT_64      = 8'd64;
  localparam logic [7:0]  HOPS_LEFT_255     = 8'd255;
  localparam logic [63:0] LINK_LOCAL_PREFIX = 64'hFE80_0000_0000_0000;
  localparam logic [63:0] MCAST_LL_PREFIX   = 64'hFF02_0000_0000_0000;
  localparam logic [63:0] UL_FLIP           = 64'h0200_0000_0000_0000;
  localparam logic [63:0] SHORT_IID_MASK    = 64'hFFFF_FFFF_FFFF_0000;
  localparam logic [63:0] SHORT_IID_PATTERN = 64'h0000_00FF_FE00_0000;
  localparam logic [7:0]  MCAST_FIRST_BYTE  = 8'hFF;

  // Traffic class / flow label codes.
  localparam logic [1:0] TF_FULL     = 2'b00;
  localparam logic [1:0] TF_FL_ONLY  = 2'b01;
  localparam logic [1:0] TF_TC_ONLY  = 2'b10;
  localparam logic [1:0] TF_ELIDED   = 2'b11;

  // Hop limit codes.
  localparam logic [1:0] HLIM_INLINE = 2'b00;
  localparam logic [1:0] HLIM_1      = 2'b01;
  localparam logic [1:0] HLIM_64     = 2'b10;
  localparam logic [1:0] HLIM_255    = 2'b11;

  // Address mode codes (SAM and DAM share them).
  localparam logic [1:0] AM_INLINE_128 = 2'b00;
  localparam logic [1:0] AM_INLINE_64  = 2'b01;
  localparam logic [1:0] AM_INLINE_16  = 2'b10;
  localparam logic [1:0] AM_ELIDED     = 2'b11;

  // Segments of the compressed header, in wire order.
  typedef enum logic [2:0] {
    SEG_IPHC0,
    SEG_IPHC1,
    SEG_TF,
    SEG_NH,
    SEG_HL,
    SEG_SRC,
    SEG_DST
  } seg_t;

  localparam int NUM_SEGS = 7;

  // One classified header: IPHC words plus each inline segment,
  // left aligned, with its byte count.
  typedef struct packed {
    logic [7:0]   iphc0;
    logic [7:0]   iphc1;
    logic [31:0]  tf_word;
    logic [2:0]   tf_count;
    logic [7:0]   next_header;
    logic         nh_count;
    logic [7:0]   hops_left;
    logic         hl_count;
    logic [127:0] src_word;
    logic [4:0]   src_count;
    logic [127:0] dst_word;
    logic [4:0]   dst_count;
  } iphc_desc_t;

endpackage

>>> rtl/iphc_front.sv
// ----------------------------------------------------------------------------
// IPHC classifier
// Accepts one IPv6 header request, picks the TF, NH, HLIM, SAM and DAM
// encodings and registers a descriptor of the inline segments.
// ----------------------------------------------------------------------------
module iphc_front
  import iphc_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  logic         in_valid,
  output logic         in_ready,
  input  logic [7:0]   traffic_class,
  input  logic [19:0]  flow_label,
  input  logic [7:0]   next_header,
  input  logic [7:0]   hops_left,
  input  logic [63:0]  source_prefix,
  input  logic [63:0]  source_iid,
  input  logic [63:0]  dest_prefix,
  input  logic [63:0]  dest_iid,
  input  logic [63:0]  source_link_address,
  input  logic [63:0]  dest_link_address,
  output logic         desc_valid,
  input  logic         desc_ready,
  output iphc_desc_t   desc
);

  iphc_desc_t desc_next;
  logic [1:0] tf_code;
  logic       nh_bit;
  logic [1:0] hlim_code;
  logic       sac;
  logic [1:0] sam;
  logic       mcast;
  logic [1:0] dam;
  logic [7:0] ecn_dscp;

  // The stage takes a new request whenever its register is free or drains.
  assign in_ready = !desc_valid || desc_ready;

  // Classify the header and lay out each inline segment.
  always_comb begin
    desc_next = '0;
    ecn_dscp  = {traffic_class[1:0], traffic_class[7:2]};

    // Traffic class and flow label.
    if (flow_label == 20'd0) begin
      if (traffic_class == 8'd0) begin
        tf_code = TF_ELIDED;
      end else begin
        tf_code             = TF_TC_ONLY;
        desc_next.tf_word   = {ecn_dscp, 24'd0};
        desc_next.tf_count  = 3'd1;
      end
    end else if (traffic_class == 8'd0) begin
      tf_code            = TF_FL_ONLY;
      desc_next.tf_word  = {4'd0, flow_label, 8'd0};
      desc_next.tf_count = 3'd3;
    end else begin
      tf_code            = TF_FULL;
      desc_next.tf_word  = {ecn_dscp, 4'd0, flow_label};
      desc_next.tf_count = 3'd4;
    end

    // Next header: UDP is only flagged.
    desc_next.next_header = next_header;
    nh_bit                = (next_header == PROTO_UDP);
    desc_next.nh_count    = !nh_bit;

    // Hop limit.
    desc_next.hops_left = hops_left;
    desc_next.hl_count  = 1'b0;
    if (hops_left == HOPS_LEFT_1) begin
      hlim_code = HLIM_1;
    end else if (hops_left == HOPS_LEFT_64) begin
      hlim_code = HLIM_64;
    end else if (hops_left == HOPS_LEFT_255) begin
      hlim_code = HLIM_255;
    end else begin
      hlim_code          = HLIM_INLINE;
      desc_next.hl_count = 1'b1;
    end

    // Source address.
    sac = 1'b0;
    if (source_prefix == 64'd0 && source_iid == 64'd0) begin
      sac = 1'b1;
      sam = AM_INLINE_128;
    end else if (source_prefix == LINK_LOCAL_PREFIX) begin
      if (source_iid == (source_link_address ^ UL_FLIP)) begin
        sam = AM_ELIDED;
      end else if ((source_iid & SHORT_IID_MASK) == SHORT_IID_PATTERN) begin
        sam                 = AM_INLINE_16;
        desc_next.src_word  = {source_iid[15:0], 112'd0};
        desc_next.src_count = 5'd2;
      end else begin
        sam                 = AM_INLINE_64;
        desc_next.src_word  = {source_iid, 64'd0};
        desc_next.src_count = 5'd8;
      end
    end else begin
      sam                 = AM_INLINE_128;
      desc_next.src_word  = {source_prefix, source_iid};
      desc_next.src_count = 5'd16;
    end

    // Destination address.
    mcast = 1'b0;
    if (dest_prefix[63:56] == MCAST_FIRST_BYTE) begin
      mcast = 1'b1;
      if (dest_prefix == MCAST_LL_PREFIX && dest_iid[63:8] == 56'd0) begin
        dam                 = AM_ELIDED;
        desc_next.dst_word  = {dest_iid[7:0], 120'd0};
        desc_next.dst_count = 5'd1;
      end else if (dest_prefix[47:0] == 48'd0 && dest_iid[63:24] == 40'd0) begin
        dam                 = AM_INLINE_16;
        desc_next.dst_word  = {dest_prefix[55:48], dest_iid[23:0], 96'd0};
        desc_next.dst_count = 5'd4;
      end else if (dest_prefix[47:0] == 48'd0 && dest_iid[63:40] == 24'd0) begin
        dam                 = AM_INLINE_64;
        desc_next.dst_word  = {dest_prefix[55:48], dest_iid[39:0], 80'd0};
        desc_next.dst_count = 5'd6;
      end else begin
        dam                 = AM_INLINE_128;
        desc_next.dst_word  = {dest_prefix, dest_iid};
        desc_next.dst_count = 5'd16;
      end
    end else if (dest_prefix == LINK_LOCAL_PREFIX) begin
      if (dest_iid == (dest_link_address ^ UL_FLIP)) begin
        dam = AM_ELIDED;
      end else if ((dest_iid & SHORT_IID_MASK) == SHORT_IID_PATTERN) begin
        dam                 = AM_INLINE_16;
        desc_next.dst_word  = {dest_iid[15:0], 112'd0};
        desc_next.dst_count = 5'd2;
      end else begin
        dam                 = AM_INLINE_64;
        desc_next.dst_word  = {dest_iid, 64'd0};
        desc_next.dst_count = 5'd8;
      end
    end else begin
      dam                 = AM_INLINE_128;
      desc_next.dst_word  = {dest_prefix, dest_iid};
      desc_next.dst_count = 5'd16;
    end

    desc_next.iphc0 = {IPHC_DISPATCH, tf_code, nh_bit, hlim_code};
    desc_next.iphc1 = {1'b0, sac, sam, mcast, 1'b0, dam};
  end

  // Descriptor register; only its valid flag is reset.
  always_ff @(posedge clk) begin
    if (rst) begin
      desc_valid <= 1'b0;
    end else if (in_ready) begin
      desc_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      desc <= desc_next;
    end
  end

endmodule

>>> rtl/iphc_queue.sv
// ----------------------------------------------------------------------------
// IPHC descriptor queue
// A small FIFO that lets the classifier run ahead of the byte serializer.
// ----------------------------------------------------------------------------
module iphc_queue
  import iphc_pkg::*;
#(
  parameter int DEPTH = QUEUE_DEPTH_DEFAULT
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       push_valid,
  output logic       push_ready,
  input  iphc_desc_t push_desc,
  output logic       head_valid,
  input  logic       pop,
  output iphc_desc_t head_desc
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

  iphc_desc_t    mem [DEPTH];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;
  logic [CW-1:0] count;
  logic          push;

  assign push_ready = (count != FULL_CNT);
  assign head_valid = (count != '0);
  assign push       = push_valid && push_ready;
  assign head_desc  = mem[rd_ptr];

  // Storage.
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_desc;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == LAST_PTR) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == LAST_PTR) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

>>> rtl/iphc_back.sv
// ----------------------------------------------------------------------------
// IPHC byte serializer
// Walks the head descriptor's segments, one header byte per cycle unless
// out_ready stalls the output register; empty segments skip without a gap.
// ----------------------------------------------------------------------------
module iphc_back
  import iphc_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       head_valid,
  input  iphc_desc_t head_desc,
  output logic       pop,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] header_byte,
  output logic       last_byte
);

  seg_t          seg;
  seg_t          seg_next;
  logic [3:0]    idx;
  logic [3:0]    idx_next;
  logic          advance;
  logic [4:0]    seg_len;
  logic [NUM_SEGS-1:0] nonempty;
  logic          seg_done;
  logic          more_after;
  seg_t          later_seg;
  logic [7:0]    byte_sel;

  // Byte count of a segment of a descriptor.
  function automatic logic [4:0] seg_count(input iphc_desc_t d, input seg_t s);
    logic [4:0] n;
    unique case (s)
      SEG_IPHC0: n = 5'd1;
      SEG_IPHC1: n = 5'd1;
      SEG_TF:    n = {2'b00, d.tf_count};
      SEG_NH:    n = {4'd0, d.nh_count};
      SEG_HL:    n = {4'd0, d.hl_count};
      SEG_SRC:   n = d.src_count;
      SEG_DST:   n = d.dst_count;
      default:   n = 5'd0;
    endcase
    return n;
  endfunction

  // A byte moves whenever a descriptor waits and the output register is free.
  assign advance = head_valid && (!out_valid || out_ready);

  // Segment bookkeeping: length of the current one, the next nonempty one.
  always_comb begin
    for (int s = 0; s < NUM_SEGS; s++) begin
      nonempty[s] = (seg_count(head_desc, seg_t'(3'(s))) != 5'd0);
    end
    seg_len    = seg_count(head_desc, seg);
    seg_done   = ({1'b0, idx} + 5'd1) == seg_len;
    more_after = 1'b0;
    later_seg  = SEG_IPHC0;
    for (int s = NUM_SEGS - 1; s >= 0; s--) begin
      if (3'(s) > seg && nonempty[s]) begin
        more_after = 1'b1;
        later_seg  = seg_t'(3'(s));
      end
    end
  end

  // Next segment and byte position.
  always_comb begin
    seg_next = seg;
    idx_next = idx;
    if (advance) begin
      if (!seg_done) begin
        idx_next = idx + 4'd1;
      end else if (more_after) begin
        seg_next = later_seg;
        idx_next = 4'd0;
      end else begin
        seg_next = SEG_IPHC0;
        idx_next = 4'd0;
      end
    end
  end

  // Byte selection and release of a finished descriptor.
  always_comb begin
    unique case (seg)
      SEG_IPHC0: byte_sel = head_desc.iphc0;
      SEG_IPHC1: byte_sel = head_desc.iphc1;
      SEG_TF:    byte_sel = head_desc.tf_word[{~idx[1:0], 3'b000} +: 8];
      SEG_NH:    byte_sel = head_desc.next_header;
      SEG_HL:    byte_sel = head_desc.hops_left;
      SEG_SRC:   byte_sel = head_desc.src_word[{~idx, 3'b000} +: 8];
      SEG_DST:   byte_sel = head_desc.dst_word[{~idx, 3'b000} +: 8];
      default:   byte_sel = 8'h00;
    endcase
    pop = advance && seg_done && !more_after;
  end

  // Position registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      seg <= SEG_IPHC0;
      idx <= 4'd0;
    end else begin
      seg <= seg_next;
      idx <= idx_next;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      header_byte <= byte_sel;
      last_byte   <= seg_done && !more_after;
    end
  end

endmodule

>>> rtl/lowpan_iphc_header_compress.sv
// ----------------------------------------------------------------------------
// 6LoWPAN IPHC header compressor
// Path: a request passes the classifier register, the queue and the output
// register. Throughput: one byte per cycle while out_ready is high; a header
// is 2 to 40 bytes long, sent on the serializer's single output byte lane.
// Reset: synchronous, clears the classifier stage, the queue and the output.
// ----------------------------------------------------------------------------
module lowpan_iphc_header_compress
  import iphc_pkg::*;
#(
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEFAULT
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  traffic_class,
  input  logic [19:0] flow_label,
  input  logic [7:0]  next_header,
  input  logic [7:0]  hops_left,
  input  logic [63:0] source_prefix,
  input  logic [63:0] source_iid,
  input  logic [63:0] dest_prefix,
  input  logic [63:0] dest_iid,
  input  logic [63:0] source_link_address,
  input  logic [63:0] dest_link_address,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  header_byte,
  output logic        last_byte
);

  iphc_desc_t front_desc;
  logic       front_valid;
  logic       front_ready;
  iphc_desc_t head_desc;
  logic       head_valid;
  logic       head_pop;

  // Classifier.
  iphc_front u_front (
    .clk                 (clk),
    .rst                 (rst),
    .in_valid            (in_valid),
    .in_ready            (in_ready),
    .traffic_class       (traffic_class),
    .flow_label          (flow_label),
    .next_header         (next_header),
    .hops_left           (hops_left),
    .source_prefix       (source_prefix),
    .source_iid          (source_iid),
    .dest_prefix         (dest_prefix),
    .dest_iid            (dest_iid),
    .source_link_address (source_link_address),
    .dest_link_address   (dest_link_address),
    .desc_valid          (front_valid),
    .desc_ready          (front_ready),
    .desc                (front_desc)
  );

  // Descriptor queue.
  iphc_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (front_valid),
    .push_ready (front_ready),
    .push_desc  (front_desc),
    .head_valid (head_valid),
    .pop        (head_pop),
    .head_desc  (head_desc)
  );

  // Byte serializer.
  iphc_back u_back (
    .clk         (clk),
    .rst         (rst),
    .head_valid  (head_valid),
    .head_desc   (head_desc),
    .pop         (head_pop),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .header_byte (header_byte),
    .last_byte   (last_byte)
  );

endmodule
